>>> hw/rtl/lcv_pkg.sv
`default_nettype none

package lcv_pkg;

  localparam int MAX_BLOCK_WIDTH  = 16;
  localparam int MAX_BLOCK_HEIGHT = 16;
  localparam int TAPS             = 6;
  localparam int HIST_ROWS        = TAPS - 1;

  localparam int SAMPLE_W = 16;
  localparam int PIXEL_W  = 8;
  localparam int CFG_W    = 5;
  localparam int COL_W    = $clog2(MAX_BLOCK_WIDTH);
  localparam int ROW_W    = $clog2(MAX_BLOCK_HEIGHT + HIST_ROWS + 1);
  localparam int SLOT_W   = $clog2(HIST_ROWS);
  localparam int SUM_W    = SAMPLE_W + 1;
  // |acc| stays below 2^21; one spare bit
  localparam int ACC_W    = SUM_W + 6;
  localparam int ROUND    = 512;
  localparam int SHIFT    = 10;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 1'd1;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [SLOT_W-1:0]          slot_t;
  typedef logic [COL_W-1:0]           col_t;

  // position of the accepted sample, as seen by the datapath
  typedef struct packed {
    logic  emit;
    logic  last;
    slot_t slot;
    col_t  col;
  } lcv_pos_t;

  // ring slot that holds tap k for an item written into slot s
  function automatic slot_t rot_idx(input slot_t s, input int k);
    logic [SLOT_W:0] sum;
    sum = {1'b0, s} + (SLOT_W + 1)'(k);
    if (sum >= (SLOT_W + 1)'(HIST_ROWS)) begin
      sum = sum - (SLOT_W + 1)'(HIST_ROWS);
    end
    return sum[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lcv_stream_if.sv
`default_nettype none

interface lcv_in_if
  import lcv_pkg::*;
  ();
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    block_start;

  modport source (output valid, output sample, output block_start, input ready);
  modport sink   (input valid, input sample, input block_start, output ready);
endinterface

interface lcv_out_if
  import lcv_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               last_pixel;

  modport source (output valid, output pixel, output last_pixel, input ready);
  modport sink   (input valid, input pixel, input last_pixel, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/luma_center_halfpel_vfilter.sv
// Channel  | Dir | Handshake        | Payload
// ---------+-----+------------------+------------------------------------------
// in_      | in  | valid/ready      | sample (s16), block_start
// out_     | out | valid/ready      | pixel (u8), last_pixel
// cfg_     | in  | cfg_we           | cfg_idx: 0 block_width, 1 block_height
//
// One transaction per cycle sustained while out_ready stays high. An accepted
// input passes line store read, tap sums, weighted sum and clip into the
// output register before its pixel is on out_. The first five rows of each
// block feed the line stores and produce no pixel.
// Reset (synchronous, rst_n low) clears position and pipeline valids, sets
// block width and height to 16; line stores keep their contents until written.
// Each stage moves when the stage after it is empty or moving, so bubbles
// collapse and out_ready low stalls only what is behind a full stage.
`default_nettype none

module luma_center_halfpel_vfilter
  import lcv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  lcv_in_if.sink                    in_stream,
  lcv_out_if.source                 out_stream,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  logic     accept;
  logic     load_ready;
  lcv_pos_t pos;
  sample_t  taps [HIST_ROWS];

  assign in_stream.ready = load_ready;
  assign accept          = in_stream.valid && load_ready;

  // column/row tracking and config registers
  lcv_pos u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_idx     (cfg_idx),
    .cfg_wdata   (cfg_wdata),
    .accept      (accept),
    .block_start (in_stream.block_start),
    .pos         (pos)
  );

  // five-row ring of line stores, written in the slot of the current row
  lcv_line_store u_lines (
    .clk    (clk),
    .accept (accept),
    .col    (pos.col),
    .slot   (pos.slot),
    .sample (in_stream.sample),
    .taps   (taps)
  );

  // six-tap vertical filter pipeline
  lcv_filter u_filter (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .pos        (pos),
    .sample     (in_stream.sample),
    .taps       (taps),
    .load_ready (load_ready),
    .out_ch     (out_stream)
  );

endmodule

`default_nettype wire

>>> hw/rtl/lcv_pos.sv
`default_nettype none

module lcv_pos
  import lcv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 accept,
  input  wire logic                 block_start,
  output lcv_pos_t                  pos
);

  logic [CFG_W-1:0]  width_r, height_r;
  logic [ROW_W-1:0]  col_r, row_r;
  slot_t             slot_r;
  logic [ROW_W-1:0]  col_nxt, row_nxt;
  slot_t             slot_nxt;
  logic [CFG_W-1:0]  eff_w, eff_h;
  logic [ROW_W-1:0]  rows;
  logic              fold;
  logic [ROW_W-1:0]  c, r;
  slot_t             s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(MAX_BLOCK_WIDTH);
      height_r <= CFG_W'(MAX_BLOCK_HEIGHT);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_BLOCK_WIDTH:  width_r  <= cfg_wdata;
        REG_BLOCK_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = width_r;
    if (width_r == '0) eff_w = CFG_W'(1);
    else if (width_r > CFG_W'(MAX_BLOCK_WIDTH)) eff_w = CFG_W'(MAX_BLOCK_WIDTH);
    eff_h = height_r;
    if (height_r == '0) eff_h = CFG_W'(1);
    else if (height_r > CFG_W'(MAX_BLOCK_HEIGHT)) eff_h = CFG_W'(MAX_BLOCK_HEIGHT);
    rows = ROW_W'(eff_h) + ROW_W'(HIST_ROWS);

    // new block on request, or when a width/height change left us out of bounds
    fold = block_start || (col_r >= ROW_W'(eff_w)) || (row_r >= rows);
    c = fold ? '0 : col_r;
    r = fold ? '0 : row_r;
    s = fold ? '0 : slot_r;

    pos.col  = c[COL_W-1:0];
    pos.slot = s;
    pos.emit = (r >= ROW_W'(HIST_ROWS));
    pos.last = (r == rows - ROW_W'(1)) && (c == ROW_W'(eff_w) - ROW_W'(1));

    col_nxt  = c + ROW_W'(1);
    row_nxt  = r;
    slot_nxt = s;
    if (col_nxt >= ROW_W'(eff_w)) begin
      col_nxt = '0;
      row_nxt = r + ROW_W'(1);
      slot_nxt = (s == slot_t'(HIST_ROWS - 1)) ? '0 : s + slot_t'(1);
      if (row_nxt >= rows) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      slot_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      slot_r <= slot_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/lcv_line_store.sv
`default_nettype none

module lcv_line_store
  import lcv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    accept,
  input  wire col_t    col,
  input  wire slot_t   slot,
  input  wire sample_t sample,
  output sample_t      taps [HIST_ROWS]
);

  // one bank per ring slot; read-first, so each bank returns the older row
  for (genvar b = 0; b < HIST_ROWS; b++) begin : g_bank
    sample_t mem [MAX_BLOCK_WIDTH];
    sample_t rd_r;

    always_ff @(posedge clk) begin
      if (accept) begin
        rd_r <= mem[col];
        if (slot == slot_t'(b)) begin
          mem[col] <= sample;
        end
      end
    end

    assign taps[b] = rd_r;
  end

endmodule

`default_nettype wire

>>> hw/rtl/lcv_filter.sv
`default_nettype none

module lcv_filter
  import lcv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     accept,
  input  wire lcv_pos_t pos,
  input  wire sample_t  sample,
  input  wire sample_t  taps [HIST_ROWS],
  output logic          load_ready,
  lcv_out_if.source     out_ch
);

  logic rdy1, rdy2, rdy3, rdy4;

  logic    v1_r, last1_r;
  slot_t   slot1_r;
  sample_t samp1_r;

  logic                    v2_r, last2_r;
  logic signed [SUM_W-1:0] sa2_r, sbe2_r, scd2_r;

  logic                    v3_r, last3_r;
  logic signed [ACC_W-1:0] acc3_r;

  logic               v4_r, last4_r;
  logic [PIXEL_W-1:0] pix4_r;

  sample_t                 t [HIST_ROWS];
  logic signed [SUM_W-1:0] sa_nxt, sbe_nxt, scd_nxt;
  logic signed [ACC_W-1:0] acc_nxt;
  logic [ACC_W-SHIFT-1:0]  q;
  logic [PIXEL_W-1:0]      pix_nxt;

  assign rdy4 = !v4_r || out_ch.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign load_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= accept && pos.emit;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: line store read is in flight; hold position info and new sample
  always_ff @(posedge clk) begin
    if (accept) begin
      last1_r <= pos.last;
      slot1_r <= pos.slot;
      samp1_r <= sample;
    end
  end

  // stage 2: rotate ring to oldest..newest, pairwise sums
  always_comb begin
    for (int k = 0; k < HIST_ROWS; k++) begin
      t[k] = taps[rot_idx(slot1_r, k)];
    end
    sa_nxt  = SUM_W'(t[0]) + SUM_W'(samp1_r);
    sbe_nxt = SUM_W'(t[1]) + SUM_W'(t[4]);
    scd_nxt = SUM_W'(t[2]) + SUM_W'(t[3]);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      last2_r <= last1_r;
      sa2_r   <= sa_nxt;
      sbe2_r  <= sbe_nxt;
      scd2_r  <= scd_nxt;
    end
  end

  // stage 3: shift-add weights, 5x and 20x
  always_comb begin
    acc_nxt = ACC_W'(sa2_r)
            - (ACC_W'(sbe2_r) <<< 2) - ACC_W'(sbe2_r)
            + (ACC_W'(scd2_r) <<< 4) + (ACC_W'(scd2_r) <<< 2)
            + ACC_W'(ROUND);
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      last3_r <= last2_r;
      acc3_r  <= acc_nxt;
    end
  end

  // stage 4: scale and clip to 0..255
  always_comb begin
    q = acc3_r[ACC_W-1:SHIFT];
    if (acc3_r < 0) pix_nxt = '0;
    else if (|q[ACC_W-SHIFT-1:PIXEL_W]) pix_nxt = '1;
    else pix_nxt = q[PIXEL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      last4_r <= last3_r;
      pix4_r  <= pix_nxt;
    end
  end

  assign out_ch.valid      = v4_r;
  assign out_ch.pixel      = pix4_r;
  assign out_ch.last_pixel = last4_r;

endmodule

`default_nettype wire

>>> tb/tb.sv
`default_nettype none

// Vertical six-tap center half-pel filter: self-checking bench.
// Samples go in as raster-order blocks, each pixel is predicted when its
// sample transaction is accepted and matched in order against out_stream.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcv_pkg::*;

  localparam int PIPE_SLACK = 8;       // pipeline is four deep, leave margin
  localparam int CYCLE_LIMIT = 400000; // watchdog
  localparam int NUM_PHASES = 12;

  typedef logic [PIXEL_W-1:0] pixel_t;

  typedef struct {
    sample_t sample;
    logic    block_start;
    bit      hold;        // wait for every pixel due before offering this one
  } sample_txn_t;

  typedef struct {
    pixel_t pixel;
    logic   last_pixel;
  } pixel_result_t;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  lcv_in_if  samples_if ();
  lcv_out_if pixels_if ();

  luma_center_halfpel_vfilter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (samples_if),
    .out_stream (pixels_if),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata)
  );

  // ------------------------------------------------------------------
  // Shared bench state
  // ------------------------------------------------------------------
  sample_txn_t   samples_to_send[$];
  pixel_result_t pixels_due[$];
  bit            in_taken;       // set at posedge on an input transaction
  int            send_idle_pct;
  int            stall_pct;
  int            mismatches;
  int            cycle_count;

  // Filter shadow: registers, position and line stores
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [4:0]       col_pos;
  logic [4:0]       row_pos;
  sample_t          line_store [HIST_ROWS][MAX_BLOCK_WIDTH];

  // ------------------------------------------------------------------
  // Pixel prediction for one accepted sample
  // ------------------------------------------------------------------
  function automatic void predict_pixel(input sample_t s, input logic start,
                                        output bit emit, output pixel_t pix,
                                        output logic last_flag);
    int w, rows, col, row, slot, a, b, c, d, e, acc, v;
    w    = (width_reg == 0) ? 1 :
           (width_reg > MAX_BLOCK_WIDTH) ? MAX_BLOCK_WIDTH : int'(width_reg);
    rows = ((height_reg == 0) ? 1 :
            (height_reg > MAX_BLOCK_HEIGHT) ? MAX_BLOCK_HEIGHT : int'(height_reg))
           + HIST_ROWS;
    col  = int'(col_pos);
    row  = int'(row_pos);
    // block_start, or a register write that left us out of bounds,
    // restarts at the top-left corner
    if (start || col >= w || row >= rows) begin
      col = 0;
      row = 0;
    end
    slot      = row % HIST_ROWS;
    emit      = 0;
    pix       = '0;
    last_flag = 1'b0;
    if (row >= HIST_ROWS) begin
      // ring: own slot holds the oldest row, the next ones get newer
      a   = line_store[slot][col];
      b   = line_store[(row + 1) % HIST_ROWS][col];
      c   = line_store[(row + 2) % HIST_ROWS][col];
      d   = line_store[(row + 3) % HIST_ROWS][col];
      e   = line_store[(row + 4) % HIST_ROWS][col];
      acc = (a + s) - 5 * (b + e) + 20 * (c + d) + ROUND;
      if (acc < 0) begin
        pix = '0;
      end else begin
        v   = acc >>> SHIFT;
        pix = (v > 255) ? pixel_t'(255) : pixel_t'(v);
      end
      last_flag = (row == rows - 1) && (col == w - 1);
      emit      = 1;
    end
    line_store[slot][col] = s;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= rows) row = 0;
    end
    col_pos = col[4:0];
    row_pos = row[4:0];
  endfunction

  // ------------------------------------------------------------------
  // Clock
  // ------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Monitor: config shadow, prediction on input transactions, checking
  // on output transactions. Everything sampled at the rising edge.
  // ------------------------------------------------------------------
  always @(posedge clk) begin
    pixel_result_t due;
    bit            emit;
    pixel_t        pix;
    logic          last_flag;
    if (!rst_n) begin
      width_reg  = CFG_W'(MAX_BLOCK_WIDTH);
      height_reg = CFG_W'(MAX_BLOCK_HEIGHT);
      col_pos    = '0;
      row_pos    = '0;
      in_taken   = 0;
      pixels_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_BLOCK_WIDTH: begin
            width_reg = cfg_wdata;
          end
          REG_BLOCK_HEIGHT: begin
            height_reg = cfg_wdata;
          end
        endcase
      end
      if (samples_if.valid && samples_if.ready) begin
        predict_pixel(samples_if.sample, samples_if.block_start, emit, pix, last_flag);
        if (emit) begin
          due.pixel      = pix;
          due.last_pixel = last_flag;
          pixels_due.push_back(due);
        end
        in_taken = 1;
      end
      if (pixels_if.valid && pixels_if.ready) begin
        if (pixels_due.size() == 0) begin
          $error("unexpected pixel transaction: pixel %0d last_pixel %0d",
                 pixels_if.pixel, pixels_if.last_pixel);
          mismatches++;
        end else begin
          due = pixels_due.pop_front();
          if (pixels_if.pixel !== due.pixel) begin
            $error("pixel: expected %0d, got %0d", due.pixel, pixels_if.pixel);
            mismatches++;
          end
          if (pixels_if.last_pixel !== due.last_pixel) begin
            $error("last_pixel: expected %0d, got %0d",
                   due.last_pixel, pixels_if.last_pixel);
            mismatches++;
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Driver: offers the head of samples_to_send at the falling edge and
  // holds it until the transaction completes.
  // ------------------------------------------------------------------
  always @(negedge clk) begin
    bit taken;
    if (!rst_n) begin
      samples_if.valid <= 1'b0;
    end else begin
      taken = in_taken;
      if (taken) begin
        samples_to_send.delete(0);
        in_taken = 0;
      end
      if (samples_if.valid && !taken) begin
        // keep offering the same sample
      end else if (samples_to_send.size() != 0 &&
                   $urandom_range(0, 99) >= send_idle_pct &&
                   !(samples_to_send[0].hold && pixels_due.size() != 0)) begin
        samples_if.valid       <= 1'b1;
        samples_if.sample      <= samples_to_send[0].sample;
        samples_if.block_start <= samples_to_send[0].block_start;
      end else begin
        samples_if.valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    pixels_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------
  task automatic queue_sample(input sample_t s, input logic start, input bit hold);
    sample_txn_t txn;
    txn.sample      = s;
    txn.block_start = start;
    txn.hold        = hold;
    samples_to_send.push_back(txn);
  endtask

  // Block is idle: nothing left to send, nothing due, pipeline flushed
  task automatic settle();
    while (samples_to_send.size() != 0 || samples_if.valid || pixels_due.size() != 0)
      @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly image-like intermediates, some full range, some rails
  function automatic sample_t next_sample();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 3) begin
      case ($urandom_range(0, 3))
        0: return sample_t'(-32768);
        1: return sample_t'(32767);
        2: return sample_t'(0);
        default: return sample_t'(-1);
      endcase
    end else if (pick < 8) begin
      return sample_t'($urandom);
    end
    return sample_t'(int'($urandom_range(0, 11000)) - 1500);
  endfunction

  // Whole blocks with random content; one in ten is cut short, and the
  // block after a cut one must carry block_start. The last block is cut
  // to land on the target count.
  task automatic queue_blocks(input int width_val, input int height_val,
                              input int target, input bit pressure);
    int w, h, full, len, sent;
    bit need_start;
    w    = (width_val < 1) ? 1 : (width_val > MAX_BLOCK_WIDTH) ? MAX_BLOCK_WIDTH : width_val;
    h    = (height_val < 1) ? 1 :
           (height_val > MAX_BLOCK_HEIGHT) ? MAX_BLOCK_HEIGHT : height_val;
    full = w * (h + HIST_ROWS);
    sent = 0;
    need_start = 1;  // width may have grown, start clean
    while (sent < target) begin
      len = full;
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, full - 1);
      if (len > target - sent) len = target - sent;
      for (int i = 0; i < len; i++) begin
        queue_sample(next_sample(),
                     (i == 0) && (need_start || $urandom_range(0, 1) != 0),
                     pressure && sent == target / 2);
        sent++;
      end
      need_start = (len != full);
    end
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 47; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 47; end
      default: begin send_idle_pct = 34; stall_pct = 34; end
    endcase
  endtask

  // ------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------
  int phase_width  [NUM_PHASES] = '{16, 1, 4, 31, 8, 0, 5, 16, 2, 12, 3, 7};
  int phase_height [NUM_PHASES] = '{16, 1, 16, 0, 3, 31, 2, 1, 8, 5, 20, 7};
  // first phase gets room for one full 16x16 block
  int phase_items  [NUM_PHASES] = '{336, 126, 126, 126, 126, 126,
                                    126, 126, 126, 126, 126, 126};

  initial begin
    rst_n                  = 1'b0;
    samples_if.valid       = 1'b0;
    samples_if.sample      = '0;
    samples_if.block_start = 1'b0;
    pixels_if.ready        = 1'b0;
    cfg_we                 = 1'b0;
    cfg_idx                = REG_BLOCK_WIDTH;
    cfg_wdata              = '0;
    send_idle_pct          = 0;
    stall_pct              = 0;
    mismatches             = 0;
    cycle_count            = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // zero width and height act as 1x1: six samples per block, one pixel
    write_reg(REG_BLOCK_WIDTH, '0);
    write_reg(REG_BLOCK_HEIGHT, '0);
    // taps pushed to the rails so the sum saturates high
    queue_sample(sample_t'(32767), 1'b1, 0);
    queue_sample(sample_t'(-32768), 1'b0, 0);
    queue_sample(sample_t'(32767), 1'b0, 0);
    queue_sample(sample_t'(32767), 1'b0, 0);
    queue_sample(sample_t'(-32768), 1'b0, 0);
    queue_sample(sample_t'(32767), 1'b0, 0);
    // next block follows after the wrap, no block_start; saturates low
    queue_sample(sample_t'(-32768), 1'b0, 0);
    queue_sample(sample_t'(32767), 1'b0, 0);
    queue_sample(sample_t'(-32768), 1'b0, 0);
    queue_sample(sample_t'(-32768), 1'b0, 0);
    queue_sample(sample_t'(32767), 1'b0, 0);
    queue_sample(sample_t'(-32768), 1'b0, 0);
    settle();

    // position left past a shrunken width: next sample restarts the block
    write_reg(REG_BLOCK_WIDTH, CFG_W'(2));
    write_reg(REG_BLOCK_HEIGHT, CFG_W'(2));
    queue_sample(sample_t'(100), 1'b1, 0);
    queue_sample(sample_t'(200), 1'b0, 0);
    queue_sample(sample_t'(300), 1'b0, 0);
    settle();
    write_reg(REG_BLOCK_WIDTH, CFG_W'(1));
    queue_sample(sample_t'(0), 1'b0, 0);
    queue_sample(sample_t'(-1), 1'b0, 0);
    queue_sample(sample_t'(4000), 1'b0, 0);
    queue_sample(sample_t'(5000), 1'b0, 0);
    queue_sample(sample_t'(-1), 1'b0, 0);
    queue_sample(sample_t'(0), 1'b0, 1);
    settle();
    // position left past a shrunken height: same restart
    write_reg(REG_BLOCK_HEIGHT, '0);
    queue_sample(sample_t'(1234), 1'b0, 0);
    settle();

    // --- random phases, each with its own geometry and idling ---
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_reg(REG_BLOCK_WIDTH, CFG_W'(phase_width[ph]));
      write_reg(REG_BLOCK_HEIGHT, CFG_W'(phase_height[ph]));
      set_idling(ph % 4);
      queue_blocks(phase_width[ph], phase_height[ph], phase_items[ph], (ph % 3) == 0);
      settle();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> luma_center_halfpel_vfilter.f
hw/rtl/lcv_pkg.sv
hw/rtl/lcv_stream_if.sv
hw/rtl/lcv_pos.sv
hw/rtl/lcv_line_store.sv
hw/rtl/lcv_filter.sv
hw/rtl/luma_center_halfpel_vfilter.sv
tb/tb.sv
